@@ rtl/core/sensor_bank_edge_event_detector_core_macros.svh @@
// Assertion macros for the edge event detector RTL.
// Users need a clock named clk and an active-low reset named arst_n in scope.
`ifndef SENSOR_BANK_EDGE_EVENT_DETECTOR_CORE_MACROS_SVH
`define SENSOR_BANK_EDGE_EVENT_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SBEED_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define SBEED_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sbeed_pkg.sv @@
// Package for the sensor bank edge event detector: payload and job types,
// constants and bit-search helpers. No dependencies.
`timescale 1ns / 1ps

package sbeed_pkg;

	localparam int BANK_COUNT      = 5;
	localparam int SENSORS_IN_BANK = 16;
	localparam int QUEUE_DEPTH     = 2;

	typedef logic [SENSORS_IN_BANK-1:0] sensor_mask_t;

	// Input transaction: one bank report
	typedef struct packed {
		logic [2:0] bank_index;
		logic [7:0] status_high;
		logic [7:0] status_low;
		logic [7:0] stamp_minutes;
		logic [5:0] stamp_seconds;
		logic [3:0] stamp_tenths;
	} in_item_t;

	// Output transaction: one event
	typedef struct packed {
		logic [6:0] sensor_index;
		logic [2:0] bank_number;
		logic [4:0] sensor_number;
		logic [7:0] event_minutes;
		logic [5:0] event_seconds;
		logic [3:0] event_tenths;
		logic       last_of_bank;
	} out_item_t;

	// Work handed from front to back; mask bit p is sensor position p
	typedef struct packed {
		logic [2:0]   bank;
		sensor_mask_t pos_mask;
		logic [7:0]   minutes;
		logic [5:0]   seconds;
		logic [3:0]   tenths;
	} job_t;

	// Lowest set position (first event in ascending order)
	function automatic logic [3:0] lowest_set(sensor_mask_t m);
		logic [3:0] r;
		r = '0;
		for (int p = SENSORS_IN_BANK - 1; p >= 0; p--) begin
			if (m[p]) begin
				r = 4'(p);
			end
		end
		return r;
	endfunction

	// Highest set position (last event of a report)
	function automatic logic [3:0] highest_set(sensor_mask_t m);
		logic [3:0] r;
		r = '0;
		for (int p = 0; p < SENSORS_IN_BANK; p++) begin
			if (m[p]) begin
				r = 4'(p);
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/core/sbeed_front.sv @@
// Front end: accepts bank reports, keeps sensor levels and the last
// triggered sensor, and turns each report with events into an event job. Uses sbeed_pkg.
`timescale 1ns / 1ps

module sbeed_front import sbeed_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_data,
	input  logic     queue_full,
	output logic     in_stall,
	output logic     push,
	output job_t     push_data
);

	logic [SENSORS_IN_BANK-1:0] levels_q [BANK_COUNT];
	logic [6:0]                 last_sensor_q;
	logic                       last_valid_q;

	logic                       accept;
	logic                       bank_ok;
	logic [SENSORS_IN_BANK-1:0] word;
	logic [SENSORS_IN_BANK-1:0] old_level;
	logic [SENSORS_IN_BANK-1:0] rising;
	sensor_mask_t               edge_mask;
	logic [3:0]                 first_pos;
	sensor_mask_t               pos_mask;

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;
	assign bank_ok  = 32'(in_data.bank_index) < BANK_COUNT;
	assign word     = {in_data.status_high, in_data.status_low};

	// Rising edges, reordered by position, with the repeated sensor removed
	always_comb begin
		old_level = '0;
		for (int b = 0; b < BANK_COUNT; b++) begin
			if (32'(in_data.bank_index) == b) begin
				old_level = levels_q[b];
			end
		end
		rising = word & ~old_level;
		for (int p = 0; p < SENSORS_IN_BANK; p++) begin
			edge_mask[p] = rising[SENSORS_IN_BANK-1-p];
		end
		first_pos = lowest_set(edge_mask);
		pos_mask  = edge_mask;
		// Only the first rising sensor can repeat the record; any earlier
		// event in the same report replaces it
		if (last_valid_q && last_sensor_q[6:4] == in_data.bank_index &&
				first_pos == last_sensor_q[3:0]) begin
			pos_mask[first_pos] = 1'b0;
		end
	end

	assign push = accept && bank_ok && (pos_mask != '0);

	always_comb begin
		push_data.bank     = in_data.bank_index;
		push_data.pos_mask = pos_mask;
		push_data.minutes  = in_data.stamp_minutes;
		push_data.seconds  = in_data.stamp_seconds;
		push_data.tenths   = in_data.stamp_tenths;
	end

	// State update: levels on each accepted report for a valid bank, last sensor only when events come out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BANK_COUNT; b++) begin
				levels_q[b] <= '0;
			end
			last_sensor_q <= '0;
			last_valid_q  <= 1'b0;
		end else if (accept && bank_ok) begin
			for (int b = 0; b < BANK_COUNT; b++) begin
				if (32'(in_data.bank_index) == b) begin
					levels_q[b] <= word;
				end
			end
			if (pos_mask != '0) begin
				last_sensor_q <= {in_data.bank_index, highest_set(pos_mask)};
				last_valid_q  <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/sbeed_queue.sv @@
// Small job queue between front and back ends. Uses sbeed_pkg.
`timescale 1ns / 1ps

module sbeed_queue import sbeed_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output job_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = 32'(count_q) == QUEUE_DEPTH;
	assign pop_valid = count_q != '0;
	assign pop_data  = slots_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/sbeed_back.sv @@
// Back end: walks one job's position mask into an output register, one event
// per cycle unless out_stall holds it. Uses sbeed_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sensor_bank_edge_event_detector_core_macros.svh"

module sbeed_back import sbeed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      job_data,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	job_t         job_q;
	logic         busy_q;
	logic         out_valid_q;
	out_item_t    out_data_q;

	logic         advance;
	logic [3:0]   pos;
	sensor_mask_t remaining;

	assign pop       = job_valid && !busy_q;
	assign advance   = busy_q && (!out_valid_q || !out_stall);
	assign pos       = lowest_set(job_q.pos_mask);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		remaining      = job_q.pos_mask;
		remaining[pos] = 1'b0;
	end

	// Job register and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
		end else if (advance && remaining == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job_data;
		end else if (advance) begin
			job_q.pos_mask <= remaining;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.sensor_index  <= {job_q.bank, pos};
			out_data_q.bank_number   <= job_q.bank;
			out_data_q.sensor_number <= {1'b0, pos} + 5'd1;
			out_data_q.event_minutes <= job_q.minutes;
			out_data_q.event_seconds <= job_q.seconds;
			out_data_q.event_tenths  <= job_q.tenths;
			out_data_q.last_of_bank  <= remaining == '0;
		end
	end

	// A live job always has an event left
	`SBEED_ASSERT_IMP(a_busy_has_work, busy_q, job_q.pos_mask != '0, "busy with empty mask")
	// An event that is not the last leaves its job in progress
	`SBEED_ASSERT_IMP(a_more_pending, out_valid_q && !out_data_q.last_of_bank, busy_q,
		"non-final event without pending job")
	// Events of one job share its bank
	`SBEED_ASSERT_IMP(a_same_bank, out_valid_q && !out_data_q.last_of_bank,
		out_data_q.bank_number == job_q.bank, "event bank differs from job bank")
	// Taking a final event with nothing queued leaves the back end idle
	`SBEED_ASSERT_NXT(a_idle_after_last, advance && remaining == '0 && !job_valid, !busy_q,
		"back end still busy after final event")

endmodule

@@ rtl/core/sensor_bank_edge_event_detector_core.sv @@
// Top level of the sensor bank edge event detector: front end, job queue
// and back end. Uses sbeed_pkg, sbeed_front, sbeed_queue and sbeed_back.
//
//   channel  direction  handshake           payload
//   in       receive    in_valid/in_stall   in_data  (in_item_t, one bank report)
//   out      send       out_valid/out_stall out_data (out_item_t, one event)
//
// The front end takes a report whenever the job queue has room.
// The back end emits one event per cycle unless out_stall holds it; it loads a
// report's job, walks its events, and takes the next job only after the last one.
// Reports with no events, or for a bank beyond the last, never reach the queue.
// Reset clears all sensor levels and the last-sensor record at once.
// out_stall holds the output register; the queue absorbs reports meanwhile.
`timescale 1ns / 1ps

module sensor_bank_edge_event_detector_core import sbeed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic queue_full;
	logic push;
	job_t push_data;
	logic pop;
	logic job_valid;
	job_t job_data;

	// Report intake and classification
	sbeed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.queue_full (queue_full),
		.in_stall   (in_stall),
		.push       (push),
		.push_data  (push_data)
	);

	// Decoupling queue
	sbeed_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (job_valid),
		.pop_data  (job_data)
	);

	// Event generation
	sbeed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_data  (job_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
